@@ hw/rtl/bost_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bost_pkg;

   // Opcodes of a request
   localparam logic OP_START = 1'b0;
   localparam logic OP_DONE  = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_BULK_IN   = 2'd0;
   localparam logic [1:0] CSR_BULK_OUT  = 2'd1;
   localparam logic [1:0] CSR_INTERFACE = 2'd2;

   // Final status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_IO      = 2'd2;
   localparam logic [1:0] ST_XFER    = 2'd3;

   localparam logic [31:0] CSW_SIGNATURE = 32'h5342_5355;
   localparam logic [31:0] CBW_BYTES     = 32'd31;
   localparam logic [31:0] CSW_BYTES     = 32'd13;
   localparam logic [7:0]  DATA_WAIT_MS  = 8'd10;
   localparam logic [7:0]  FLAGS_IN      = 8'h80;
   localparam logic [7:0]  FLAGS_OUT     = 8'h00;

   typedef enum logic [2:0] {
      ACT_WRAP  = 3'd0,
      ACT_DATA  = 3'd1,
      ACT_CLEAR = 3'd2,
      ACT_STAT  = 3'd3,
      ACT_RESET = 3'd4,
      ACT_DONE  = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_WRAP = 4'd1,
      PH_DATA = 4'd2,
      PH_DCLR = 4'd3,
      PH_STAT = 4'd4,
      PH_SCLR = 4'd5,
      PH_RREQ = 4'd6,
      PH_RIN  = 4'd7,
      PH_ROUT = 4'd8
   } phase_type;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  unit_number;
      logic [7:0]  command_length;
      logic [31:0] data_length;
      logic        to_host;
      logic        action_ok;
      logic [31:0] moved_length;
      logic [31:0] status_signature;
      logic [31:0] status_tag;
      logic [31:0] status_residue;
      logic [7:0]  status_code;
   } req_type;

   // Classified request as it waits in the queue between front and back
   typedef struct packed {
      logic        start;
      logic        command_bad;
      logic [3:0]  unit_number;
      logic [4:0]  command_length;
      logic [31:0] data_length;
      logic        to_host;
      logic        action_ok;
      logic [31:0] moved_length;
      logic        signature_bad;
      logic [31:0] status_tag;
      logic [31:0] status_residue;
      logic [7:0]  status_code;
   } item_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  endpoint;
      logic        direction_in;
      logic [31:0] transfer_length;
      logic [7:0]  delay_ms;
      logic [31:0] wrapper_tag;
      logic [7:0]  wrapper_flags;
      logic [3:0]  wrapper_unit;
      logic [4:0]  wrapper_command_length;
      logic [1:0]  final_status;
      logic [31:0] residue;
   } rsp_type;

   typedef struct packed {
      logic [3:0] bulk_in_endpoint;
      logic [3:0] bulk_out_endpoint;
      logic [7:0] interface_number;
   } cfg_type;

endpackage

`default_nettype wire

@@ hw/rtl/bost_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-entry queue; the head always sits in slot 0.
module bost_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   logic [1:0]       valid_ff, valid_in;
   logic [WIDTH-1:0] slot0_ff, slot0_in;
   logic [WIDTH-1:0] slot1_ff, slot1_in;

   assign full     = valid_ff[1];
   assign empty    = !valid_ff[0];
   assign pop_data = slot0_ff;

   always_comb begin
      valid_in = valid_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (push && pop) begin
         if (valid_ff[1]) begin
            slot0_in = slot1_ff;
            slot1_in = push_data;
         end else begin
            slot0_in = push_data;
         end
      end else if (push) begin
         if (valid_ff[0]) begin
            slot1_in    = push_data;
            valid_in[1] = 1'b1;
         end else begin
            slot0_in    = push_data;
            valid_in[0] = 1'b1;
         end
      end else if (pop) begin
         slot0_in = slot1_ff;
         valid_in = {1'b0, valid_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 2'b00;
      end else begin
         valid_ff <= valid_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/bost_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Classify a request: decode the opcode, check the command length and
// the status wrapper signature before it enters the queue.
module bost_front #(
   parameter int MAX_COMMAND_BYTES = 16
) (
   input  wire bost_pkg::req_type req,
   output bost_pkg::item_type     item
);

   always_comb begin
      item.start          = (req.opcode == bost_pkg::OP_START);
      item.command_bad    = (req.command_length > 8'(MAX_COMMAND_BYTES));
      item.unit_number    = req.unit_number;
      item.command_length = req.command_length[4:0];
      item.data_length    = req.data_length;
      item.to_host        = req.to_host;
      item.action_ok      = req.action_ok;
      item.moved_length   = req.moved_length;
      item.signature_bad  = (req.status_signature != bost_pkg::CSW_SIGNATURE);
      item.status_tag     = req.status_tag;
      item.status_residue = req.status_residue;
      item.status_code    = req.status_code;
   end

endmodule

`default_nettype wire

@@ hw/rtl/bost_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Transport sequencer: one queued request per cycle while the response queue has room, next action out.
module bost_seq #(
   parameter int SETTLE_MS = 150
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bost_pkg::cfg_type  cfg,
   input  wire bost_pkg::item_type item,
   input  wire logic               item_valid,
   output logic                    item_pop,
   output bost_pkg::rsp_type       rsp,
   output logic                    rsp_push,
   input  wire logic               rsp_full
);

   localparam logic [7:0] SETTLE_DELAY = (SETTLE_MS > 255) ? 8'd255 : 8'(SETTLE_MS);

   bost_pkg::phase_type phase_ff, phase_in;
   logic [31:0] tag_ff, tag_in;
   logic        retried_ff, retried_in;
   logic [31:0] expected_ff, expected_in;
   logic [31:0] actual_ff, actual_in;
   logic        read_dir_ff, read_dir_in;
   logic [1:0]  pending_ff, pending_in;

   logic        fire;
   logic        ok;
   logic        emit;
   logic        status_bad;
   logic        status_soft;
   logic [31:0] residue;
   logic [3:0]  data_endpoint;

   assign fire          = item_valid && !rsp_full;
   assign item_pop      = fire;
   assign rsp_push      = fire && emit;
   assign ok            = item.action_ok;
   assign data_endpoint = read_dir_ff ? cfg.bulk_in_endpoint : cfg.bulk_out_endpoint;
   assign status_bad    = item.signature_bad || (item.status_tag != (tag_ff - 32'd1)) ||
                          (item.status_code >= 8'd2);
   assign status_soft   = (actual_ff > expected_ff) || (item.status_code == 8'd1);

   // Fill in the shortfall when the device reports no residue
   always_comb begin
      residue = item.status_residue;
      if (item.status_residue == 32'd0 && expected_ff != 32'd0 && expected_ff != actual_ff) begin
         residue = expected_ff - actual_ff;
      end
   end

   // Next state
   always_comb begin
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      retried_in  = retried_ff;
      expected_in = expected_ff;
      actual_in   = actual_ff;
      read_dir_in = read_dir_ff;
      pending_in  = pending_ff;
      if (fire) begin
         if (item.start) begin
            expected_in = item.data_length;
            read_dir_in = item.to_host;
            actual_in   = 32'd0;
            retried_in  = 1'b0;
            if (item.command_bad) begin
               pending_in = bost_pkg::ST_INVALID;
               phase_in   = bost_pkg::PH_RREQ;
            end else begin
               tag_in   = tag_ff + 32'd1;
               phase_in = bost_pkg::PH_WRAP;
            end
         end else begin
            case (phase_ff)
               bost_pkg::PH_WRAP: begin
                  if (!ok) begin
                     pending_in = bost_pkg::ST_XFER;
                     phase_in   = bost_pkg::PH_RREQ;
                  end else begin
                     retried_in = 1'b0;
                     phase_in   = (expected_ff == 32'd0) ? bost_pkg::PH_STAT
                                                         : bost_pkg::PH_DATA;
                  end
               end
               bost_pkg::PH_DATA: begin
                  actual_in = item.moved_length;
                  phase_in  = ok ? bost_pkg::PH_STAT : bost_pkg::PH_DCLR;
               end
               bost_pkg::PH_DCLR: begin
                  if (ok) begin
                     phase_in = bost_pkg::PH_STAT;
                  end else begin
                     pending_in = bost_pkg::ST_XFER;
                     phase_in   = bost_pkg::PH_RREQ;
                  end
               end
               bost_pkg::PH_STAT: begin
                  if (ok) begin
                     if (status_bad) begin
                        pending_in = bost_pkg::ST_IO;
                        phase_in   = bost_pkg::PH_RREQ;
                     end else begin
                        phase_in = bost_pkg::PH_IDLE;
                     end
                  end else if (retried_ff) begin
                     pending_in = bost_pkg::ST_XFER;
                     phase_in   = bost_pkg::PH_RREQ;
                  end else begin
                     phase_in = bost_pkg::PH_SCLR;
                  end
               end
               bost_pkg::PH_SCLR: begin
                  if (!ok) begin
                     pending_in = bost_pkg::ST_XFER;
                     phase_in   = bost_pkg::PH_RREQ;
                  end else begin
                     retried_in = 1'b1;
                     phase_in   = bost_pkg::PH_STAT;
                  end
               end
               bost_pkg::PH_RREQ: phase_in = ok ? bost_pkg::PH_RIN : bost_pkg::PH_IDLE;
               bost_pkg::PH_RIN:  phase_in = ok ? bost_pkg::PH_ROUT : bost_pkg::PH_IDLE;
               bost_pkg::PH_ROUT: phase_in = bost_pkg::PH_IDLE;
               default:           phase_in = phase_ff;
            endcase
         end
      end
   end

   // Result
   always_comb begin
      rsp  = '0;
      emit = 1'b1;
      if (item.start) begin
         if (item.command_bad) begin
            rsp.action = bost_pkg::ACT_RESET;
         end else begin
            rsp.action                 = bost_pkg::ACT_WRAP;
            rsp.endpoint               = cfg.bulk_out_endpoint;
            rsp.transfer_length        = bost_pkg::CBW_BYTES;
            rsp.wrapper_tag            = tag_ff;
            rsp.wrapper_flags          = item.to_host ? bost_pkg::FLAGS_IN : bost_pkg::FLAGS_OUT;
            rsp.wrapper_unit           = item.unit_number;
            rsp.wrapper_command_length = item.command_length;
         end
      end else begin
         case (phase_ff)
            bost_pkg::PH_WRAP: begin
               if (!ok) begin
                  rsp.action = bost_pkg::ACT_RESET;
               end else if (expected_ff == 32'd0) begin
                  rsp.action          = bost_pkg::ACT_STAT;
                  rsp.endpoint        = cfg.bulk_in_endpoint;
                  rsp.direction_in    = 1'b1;
                  rsp.transfer_length = bost_pkg::CSW_BYTES;
                  rsp.delay_ms        = bost_pkg::DATA_WAIT_MS;
               end else begin
                  rsp.action          = bost_pkg::ACT_DATA;
                  rsp.endpoint        = data_endpoint;
                  rsp.direction_in    = read_dir_ff;
                  rsp.transfer_length = expected_ff;
                  rsp.delay_ms        = bost_pkg::DATA_WAIT_MS;
               end
            end
            bost_pkg::PH_DATA: begin
               if (ok) begin
                  rsp.action          = bost_pkg::ACT_STAT;
                  rsp.endpoint        = cfg.bulk_in_endpoint;
                  rsp.direction_in    = 1'b1;
                  rsp.transfer_length = bost_pkg::CSW_BYTES;
               end else begin
                  rsp.action       = bost_pkg::ACT_CLEAR;
                  rsp.endpoint     = data_endpoint;
                  rsp.direction_in = read_dir_ff;
               end
            end
            bost_pkg::PH_DCLR, bost_pkg::PH_SCLR: begin
               if (ok) begin
                  rsp.action          = bost_pkg::ACT_STAT;
                  rsp.endpoint        = cfg.bulk_in_endpoint;
                  rsp.direction_in    = 1'b1;
                  rsp.transfer_length = bost_pkg::CSW_BYTES;
               end else begin
                  rsp.action = bost_pkg::ACT_RESET;
               end
            end
            bost_pkg::PH_STAT: begin
               if (ok) begin
                  if (status_bad) begin
                     rsp.action = bost_pkg::ACT_RESET;
                  end else begin
                     rsp.action       = bost_pkg::ACT_DONE;
                     rsp.final_status = status_soft ? bost_pkg::ST_IO : bost_pkg::ST_OK;
                     rsp.residue      = residue;
                  end
               end else if (retried_ff) begin
                  rsp.action = bost_pkg::ACT_RESET;
               end else begin
                  rsp.action       = bost_pkg::ACT_CLEAR;
                  rsp.endpoint     = cfg.bulk_in_endpoint;
                  rsp.direction_in = 1'b1;
               end
            end
            bost_pkg::PH_RREQ: begin
               if (ok) begin
                  rsp.action       = bost_pkg::ACT_CLEAR;
                  rsp.endpoint     = cfg.bulk_in_endpoint;
                  rsp.direction_in = 1'b1;
                  rsp.delay_ms     = SETTLE_DELAY;
               end else begin
                  rsp.action       = bost_pkg::ACT_DONE;
                  rsp.final_status = pending_ff;
               end
            end
            bost_pkg::PH_RIN: begin
               if (ok) begin
                  rsp.action   = bost_pkg::ACT_CLEAR;
                  rsp.endpoint = cfg.bulk_out_endpoint;
                  rsp.delay_ms = SETTLE_DELAY;
               end else begin
                  rsp.action       = bost_pkg::ACT_DONE;
                  rsp.final_status = pending_ff;
               end
            end
            bost_pkg::PH_ROUT: begin
               rsp.action       = bost_pkg::ACT_DONE;
               rsp.final_status = pending_ff;
               rsp.delay_ms     = ok ? SETTLE_DELAY : 8'd0;
            end
            default: emit = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= bost_pkg::PH_IDLE;
         tag_ff      <= 32'd0;
         retried_ff  <= 1'b0;
         expected_ff <= 32'd0;
         actual_ff   <= 32'd0;
         read_dir_ff <= 1'b0;
         pending_ff  <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         tag_ff      <= tag_in;
         retried_ff  <= retried_in;
         expected_ff <= expected_in;
         actual_ff   <= actual_in;
         read_dir_ff <= read_dir_in;
         pending_ff  <= pending_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/bulk_only_storage_transport.sv @@
// Host-side bulk-only mass storage transport sequencer.
// Request channel: drive req_data and raise push while full is low; a start
// request opens a command, a completion request reports on the last action.
// Response channel: while empty is low, rsp_data holds the oldest action
// (send wrapper, data, clear halt, read status, reset request, finished);
// raise pop to take it. A completion that arrives with no command open
// yields no response.
// Configuration: csr_wr_en, csr_index and csr_data write the IN endpoint,
// OUT endpoint and interface number; write only while the block is idle.
// A taken request is registered in the request queue; the sequencer step
// then writes its response into the response queue, from which pop takes it.
// Throughput: one request per cycle while the response queue has room, set
// by the sequencer step between the two-entry request and response queues.
// When the receiver stalls, the response queue fills, the sequencer holds,
// and the request queue fills until full rises; nothing is dropped.
// Reset (synchronous, active high) empties both queues, returns the
// sequencer to idle, clears the tag counter and the configuration.
`timescale 1ns / 1ps
`default_nettype none

module bulk_only_storage_transport #(
   parameter int MAX_COMMAND_BYTES = 16,
   parameter int SETTLE_MS         = 150
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire bost_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output bost_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data
);

   bost_pkg::cfg_type  cfg_ff, cfg_in;
   bost_pkg::item_type front_item;
   bost_pkg::item_type queued_item;
   bost_pkg::rsp_type  seq_rsp;
   logic               item_empty;
   logic               item_pop;
   logic               rsp_push;
   logic               rsp_full;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            bost_pkg::CSR_BULK_IN:   cfg_in.bulk_in_endpoint  = csr_data[3:0];
            bost_pkg::CSR_BULK_OUT:  cfg_in.bulk_out_endpoint = csr_data[3:0];
            bost_pkg::CSR_INTERFACE: cfg_in.interface_number  = csr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify the incoming request
   bost_front #(
      .MAX_COMMAND_BYTES(MAX_COMMAND_BYTES)
   ) u_front (
      .req (req_data),
      .item(front_item)
   );

   // Hold classified requests until the sequencer takes them
   bost_queue #(
      .WIDTH($bits(bost_pkg::item_type))
   ) u_req_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push && !full),
      .push_data(front_item),
      .full     (full),
      .pop      (item_pop),
      .pop_data (queued_item),
      .empty    (item_empty)
   );

   // Back: advance the transport one request per cycle while the response queue has room
   bost_seq #(
      .SETTLE_MS(SETTLE_MS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .item      (queued_item),
      .item_valid(!item_empty),
      .item_pop  (item_pop),
      .rsp       (seq_rsp),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   // Hold responses until the receiver pops them
   bost_queue #(
      .WIDTH($bits(bost_pkg::rsp_type))
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(seq_rsp),
      .full     (rsp_full),
      .pop      (pop && !empty),
      .pop_data (rsp_data),
      .empty    (empty)
   );

endmodule

`default_nettype wire

@@ verif/tb_bulk_only_storage_transport.sv @@
`timescale 1ns / 1ps

module tb_bulk_only_storage_transport;

   localparam int CLOCK_PERIOD    = 10;
   localparam int MAX_CMD_BYTES   = 16;
   localparam int SETTLE_MS       = 150;
   localparam logic [7:0] SETTLE_DELAY = (SETTLE_MS > 255) ? 8'd255 : 8'(SETTLE_MS);
   localparam int PIPE_CYCLES     = 8;    // comfortably past the response latency
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int PHASE_REQUESTS  = 425;  // four phases give about 1700 requests
   localparam int CALM_REQUESTS   = 300;
   localparam logic [3:0] DIR_IN_EP  = 4'd5;
   localparam logic [3:0] DIR_OUT_EP = 4'd10;
   localparam bost_pkg::rsp_type NO_RSP = '0;

   typedef enum logic [1:0] {
      ROW_PREDICT,   // expected action comes from the sequencer model below
      ROW_RESULT,    // expected action typed into the row
      ROW_SILENT     // request must produce no action
   } row_kind_type;

   typedef struct {
      bost_pkg::req_type req;
      row_kind_type      kind;
      bost_pkg::rsp_type want;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    push      = 1'b0;
   logic    pop       = 1'b0;
   bost_pkg::req_type req_data = '0;
   logic    csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data  = '0;
   logic    full;
   logic    empty;
   bost_pkg::rsp_type rsp_data;

   // Model of the sequencer and its copy of the configuration
   bost_pkg::phase_type seq_phase = bost_pkg::PH_IDLE;
   logic [31:0] next_tag   = '0;
   logic        retried    = 1'b0;
   logic [31:0] want_len   = '0;
   logic [31:0] moved_len  = '0;
   logic        read_dir   = 1'b0;
   logic [1:0]  pend_status = bost_pkg::ST_OK;
   logic [3:0]  ep_in      = '0;
   logic [3:0]  ep_out     = '0;
   logic [7:0]  if_num     = '0;

   bost_pkg::rsp_type pending_actions[$];
   int      errors      = 0;
   int      idle_cycles = 0;
   bit      calm        = 1'b0;

   bulk_only_storage_transport #(
      .MAX_COMMAND_BYTES(MAX_CMD_BYTES),
      .SETTLE_MS(SETTLE_MS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Builders for requests and actions
   // ---------------------------------------------------------------------
   function automatic bost_pkg::req_type start_req(logic [3:0] unit, logic [7:0] clen,
                                                   logic [31:0] dlen, logic host);
      bost_pkg::req_type r;
      r = '0;
      r.opcode         = bost_pkg::OP_START;
      r.unit_number    = unit;
      r.command_length = clen;
      r.data_length    = dlen;
      r.to_host        = host;
      return r;
   endfunction

   function automatic bost_pkg::req_type done_req(logic ok, logic [31:0] moved,
                                                  logic [31:0] sig, logic [31:0] tag,
                                                  logic [31:0] res, logic [7:0] code);
      bost_pkg::req_type r;
      r = '0;
      r.opcode           = bost_pkg::OP_DONE;
      r.action_ok        = ok;
      r.moved_length     = moved;
      r.status_signature = sig;
      r.status_tag       = tag;
      r.status_residue   = res;
      r.status_code      = code;
      return r;
   endfunction

   function automatic bost_pkg::rsp_type act_rsp(bost_pkg::action_type act, logic [3:0] ep,
                                                 logic dir, logic [31:0] len,
                                                 logic [7:0] dly);
      bost_pkg::rsp_type o;
      o = '0;
      o.action          = act;
      o.endpoint        = ep;
      o.direction_in    = dir;
      o.transfer_length = len;
      o.delay_ms        = dly;
      return o;
   endfunction

   function automatic bost_pkg::rsp_type wrap_rsp(logic [3:0] ep, logic [31:0] tag,
                                                  logic [7:0] flags, logic [3:0] unit,
                                                  logic [4:0] clen);
      bost_pkg::rsp_type o;
      o = act_rsp(bost_pkg::ACT_WRAP, ep, 1'b0, bost_pkg::CBW_BYTES, 8'd0);
      o.wrapper_tag            = tag;
      o.wrapper_flags          = flags;
      o.wrapper_unit           = unit;
      o.wrapper_command_length = clen;
      return o;
   endfunction

   function automatic bost_pkg::rsp_type done_rsp(logic [1:0] st, logic [31:0] res,
                                                  logic [7:0] dly);
      bost_pkg::rsp_type o;
      o = act_rsp(bost_pkg::ACT_DONE, 4'd0, 1'b0, 32'd0, dly);
      o.final_status = st;
      o.residue      = res;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Sequencer model: one accepted request in, at most one action out
   // ---------------------------------------------------------------------
   task automatic finish_cmd(input logic [1:0] st, input logic [31:0] res,
                             input logic [7:0] dly, output bost_pkg::rsp_type o);
      o = done_rsp(st, res, dly);
      seq_phase = bost_pkg::PH_IDLE;
   endtask

   // Enter reset recovery; the status is reported once the three steps end
   task automatic begin_recovery(input logic [1:0] st, output bost_pkg::rsp_type o);
      pend_status = st;
      seq_phase = bost_pkg::PH_RREQ;
      o = act_rsp(bost_pkg::ACT_RESET, 4'd0, 1'b0, 32'd0, 8'd0);
   endtask

   task automatic read_status(input logic [7:0] dly, output bost_pkg::rsp_type o);
      seq_phase = bost_pkg::PH_STAT;
      o = act_rsp(bost_pkg::ACT_STAT, ep_in, 1'b1, bost_pkg::CSW_BYTES, dly);
   endtask

   task automatic sequence_step(input bost_pkg::req_type r, output bit produced,
                                output bost_pkg::rsp_type o);
      logic [31:0] res;
      logic [3:0]  data_ep;
      produced = 1'b1;
      o = '0;
      data_ep = read_dir ? ep_in : ep_out;
      if (r.opcode == bost_pkg::OP_START) begin
         // A start always abandons whatever command is running
         want_len  = r.data_length;
         read_dir  = r.to_host;
         moved_len = '0;
         retried   = 1'b0;
         if (r.command_length > MAX_CMD_BYTES) begin
            begin_recovery(bost_pkg::ST_INVALID, o);
         end else begin
            o = wrap_rsp(ep_out, next_tag,
                         r.to_host ? bost_pkg::FLAGS_IN : bost_pkg::FLAGS_OUT,
                         r.unit_number, r.command_length[4:0]);
            next_tag  = next_tag + 32'd1;
            seq_phase = bost_pkg::PH_WRAP;
         end
      end else begin
         case (seq_phase)
            bost_pkg::PH_WRAP: begin
               if (!r.action_ok) begin
                  begin_recovery(bost_pkg::ST_XFER, o);
               end else if (want_len == '0) begin
                  retried = 1'b0;
                  read_status(bost_pkg::DATA_WAIT_MS, o);
               end else begin
                  retried   = 1'b0;
                  seq_phase = bost_pkg::PH_DATA;
                  o = act_rsp(bost_pkg::ACT_DATA, data_ep, read_dir, want_len,
                              bost_pkg::DATA_WAIT_MS);
               end
            end
            bost_pkg::PH_DATA: begin
               moved_len = r.moved_length;
               if (r.action_ok) begin
                  read_status(8'd0, o);
               end else begin
                  seq_phase = bost_pkg::PH_DCLR;
                  o = act_rsp(bost_pkg::ACT_CLEAR, data_ep, read_dir, 32'd0, 8'd0);
               end
            end
            bost_pkg::PH_DCLR: begin
               if (r.action_ok) read_status(8'd0, o);
               else begin_recovery(bost_pkg::ST_XFER, o);
            end
            bost_pkg::PH_STAT: begin
               if (r.action_ok) begin
                  // Fill in the shortfall when the device reports no residue
                  res = r.status_residue;
                  if (res == '0 && want_len != '0 && want_len != moved_len)
                     res = want_len - moved_len;
                  if (r.status_signature != bost_pkg::CSW_SIGNATURE
                      || r.status_tag != next_tag - 32'd1 || r.status_code >= 8'd2)
                     begin_recovery(bost_pkg::ST_IO, o);
                  else if (moved_len > want_len || r.status_code == 8'd1)
                     finish_cmd(bost_pkg::ST_IO, res, 8'd0, o);
                  else
                     finish_cmd(bost_pkg::ST_OK, res, 8'd0, o);
               end else if (retried) begin
                  begin_recovery(bost_pkg::ST_XFER, o);
               end else begin
                  seq_phase = bost_pkg::PH_SCLR;
                  o = act_rsp(bost_pkg::ACT_CLEAR, ep_in, 1'b1, 32'd0, 8'd0);
               end
            end
            bost_pkg::PH_SCLR: begin
               if (!r.action_ok) begin
                  begin_recovery(bost_pkg::ST_XFER, o);
               end else begin
                  retried = 1'b1;
                  read_status(8'd0, o);
               end
            end
            bost_pkg::PH_RREQ: begin
               if (!r.action_ok) begin
                  finish_cmd(pend_status, 32'd0, 8'd0, o);
               end else begin
                  seq_phase = bost_pkg::PH_RIN;
                  o = act_rsp(bost_pkg::ACT_CLEAR, ep_in, 1'b1, 32'd0, SETTLE_DELAY);
               end
            end
            bost_pkg::PH_RIN: begin
               if (!r.action_ok) begin
                  finish_cmd(pend_status, 32'd0, 8'd0, o);
               end else begin
                  seq_phase = bost_pkg::PH_ROUT;
                  o = act_rsp(bost_pkg::ACT_CLEAR, ep_out, 1'b0, 32'd0, SETTLE_DELAY);
               end
            end
            bost_pkg::PH_ROUT:
               finish_cmd(pend_status, 32'd0, r.action_ok ? SETTLE_DELAY : 8'd0, o);
            default: produced = 1'b0;   // completion with no command open
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Random requests: mostly the completion the sequencer is waiting for,
   // with plausible status wrappers, plus restarts and raw noise
   // ---------------------------------------------------------------------
   function automatic bost_pkg::req_type gen_request();
      logic [191:0] noise;
      bost_pkg::req_type r;
      int unsigned dice;
      int unsigned pick;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = bost_pkg::req_type'(noise[$bits(bost_pkg::req_type)-1:0]);
      dice = $urandom_range(99);
      if (dice < 4)
         return r;
      if (seq_phase == bost_pkg::PH_IDLE || dice < 8) begin
         r.opcode = bost_pkg::OP_START;
         r.command_length = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 17))
                                                     : 8'($urandom_range(MAX_CMD_BYTES));
         pick = $urandom_range(9);
         case (pick)
            0, 1:    r.data_length = '0;
            2:       r.data_length = '1;
            3, 4:    r.data_length = $urandom;
            default: r.data_length = $urandom_range(4096, 1);
         endcase
         return r;
      end
      r.opcode = bost_pkg::OP_DONE;
      r.action_ok = ($urandom_range(99) < 80);
      pick = $urandom_range(9);
      case (pick)
         6, 7:    r.moved_length = $urandom_range(want_len);
         8:       r.moved_length = want_len + 32'd1 + 32'($urandom_range(15));
         9:       r.moved_length = $urandom;
         default: r.moved_length = want_len;
      endcase
      if ($urandom_range(19) != 0) r.status_signature = bost_pkg::CSW_SIGNATURE;
      if ($urandom_range(19) != 0) r.status_tag = next_tag - 32'd1;
      if ($urandom_range(1) == 0) r.status_residue = '0;
      pick = $urandom_range(19);
      if (pick == 0)
         r.status_code = 8'd1;
      else if (pick > 1)
         r.status_code = 8'd0;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Hold the request until the block takes it, then record the action it owes
   task automatic apply(input bost_pkg::req_type r, input row_kind_type kind,
                        input bost_pkg::rsp_type typed, output bit produced);
      bost_pkg::rsp_type predicted;
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      sequence_step(r, produced, predicted);
      if (kind == ROW_RESULT)
         pending_actions.push_back(typed);
      else if (kind == ROW_PREDICT && produced)
         pending_actions.push_back(predicted);
   endtask

   // Drop push for a random number of cycles, unless in the calm stretch
   task automatic idle_gap();
      if (!calm) begin
         while ($urandom_range(99) < 22) begin
            push <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // Stop sending and let every owed action come out, plus pipeline slack
   task automatic drain();
      push <= 1'b0;
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [3:0] in_ep, input logic [3:0] out_ep,
                             input logic [7:0] ifn);
      csr_wr_en <= 1'b1;
      csr_index <= bost_pkg::CSR_BULK_IN;
      csr_data  <= {4'd0, in_ep};
      @(posedge clock);
      csr_index <= bost_pkg::CSR_BULK_OUT;
      csr_data  <= {4'd0, out_ep};
      @(posedge clock);
      csr_index <= bost_pkg::CSR_INTERFACE;
      csr_data  <= ifn;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ep_in  = in_ep;
      ep_out = out_ep;
      if_num = ifn;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random pop, compare every taken action field by field
   // ---------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : response_check
      bost_pkg::rsp_type want;
      if (reset) begin
         pop         <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (pop && !empty) begin
            if (pending_actions.size() == 0) begin
               errors++;
               $display("%0t ns: action expected none actual %0h", $time, rsp_data);
            end else begin
               want = pending_actions.pop_front();
               compare_field("action", want.action, rsp_data.action);
               compare_field("endpoint", want.endpoint, rsp_data.endpoint);
               compare_field("direction_in", want.direction_in, rsp_data.direction_in);
               compare_field("transfer_length", want.transfer_length,
                             rsp_data.transfer_length);
               compare_field("delay_ms", want.delay_ms, rsp_data.delay_ms);
               compare_field("wrapper_tag", want.wrapper_tag, rsp_data.wrapper_tag);
               compare_field("wrapper_flags", want.wrapper_flags, rsp_data.wrapper_flags);
               compare_field("wrapper_unit", want.wrapper_unit, rsp_data.wrapper_unit);
               compare_field("wrapper_command_length", want.wrapper_command_length,
                             rsp_data.wrapper_command_length);
               compare_field("final_status", want.final_status, rsp_data.final_status);
               compare_field("residue", want.residue, rsp_data.residue);
            end
         end
         pop <= calm || ($urandom_range(99) >= 22);
         // Count cycles with no handshake on either side for the watchdog
         if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // End the run if the block stops moving
   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_CYCLES);
      $display("bulk_only_storage_transport: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      stim_row_type rows[$];
      bit      produced;
      int      counted;
      int      run;

      // Hold reset, then release it once
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_config(DIR_IN_EP, DIR_OUT_EP, 8'hA5);

      // Completion with no command open: ignored
      rows.push_back('{done_req(1'b1, 32'd0, bost_pkg::CSW_SIGNATURE, 32'd0, 32'd0, 8'd0),
                       ROW_SILENT, NO_RSP});
      // Command block too long: full reset recovery, then invalid command
      rows.push_back('{start_req(4'd0, 8'd17, 32'd0, 1'b0),
                       ROW_RESULT,
                       act_rsp(bost_pkg::ACT_RESET, 4'd0, 1'b0, 32'd0, 8'd0)});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_RESULT,
                       act_rsp(bost_pkg::ACT_CLEAR, DIR_IN_EP, 1'b1, 32'd0, SETTLE_DELAY)});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_RESULT,
                       act_rsp(bost_pkg::ACT_CLEAR, DIR_OUT_EP, 1'b0, 32'd0, SETTLE_DELAY)});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_RESULT, done_rsp(bost_pkg::ST_INVALID, 32'd0, SETTLE_DELAY)});
      // Largest legal command, full-length read; tag still zero
      rows.push_back('{start_req(4'd15, 8'd16, 32'hFFFF_FFFF, 1'b1),
                       ROW_RESULT,
                       wrap_rsp(DIR_OUT_EP, 32'd0, bost_pkg::FLAGS_IN, 4'd15, 5'd16)});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_RESULT,
                       act_rsp(bost_pkg::ACT_DATA, DIR_IN_EP, 1'b1, 32'hFFFF_FFFF,
                               bost_pkg::DATA_WAIT_MS)});
      // Data stall, clear, status stall, clear IN, retry, good status with shortfall
      rows.push_back('{done_req(1'b0, 32'h1234_5678, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b1, 32'd0, bost_pkg::CSW_SIGNATURE, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      // Zero length skips the data phase; bad signature, then reset request fails
      rows.push_back('{start_req(4'd0, 8'd0, 32'd0, 1'b0),
                       ROW_RESULT,
                       wrap_rsp(DIR_OUT_EP, 32'd1, bost_pkg::FLAGS_OUT, 4'd0, 5'd0)});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_RESULT,
                       act_rsp(bost_pkg::ACT_STAT, DIR_IN_EP, 1'b1, bost_pkg::CSW_BYTES,
                               bost_pkg::DATA_WAIT_MS)});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd1, 32'd0, 8'd0),
                       ROW_RESULT,
                       act_rsp(bost_pkg::ACT_RESET, 4'd0, 1'b0, 32'd0, 8'd0)});
      rows.push_back('{done_req(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_RESULT, done_rsp(bost_pkg::ST_IO, 32'd0, 8'd0)});
      // Restart while busy, wrapper failure, IN clear fails during recovery
      rows.push_back('{start_req(4'd3, 8'd6, 32'd100, 1'b0), ROW_PREDICT, NO_RSP});
      rows.push_back('{start_req(4'd7, 8'd1, 32'd100, 1'b0), ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_RESULT, done_rsp(bost_pkg::ST_XFER, 32'd0, 8'd0)});
      // Overrun with status code one: io error without recovery
      rows.push_back('{start_req(4'd9, 8'd16, 32'd4, 1'b1), ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b1, 32'd8, 32'd0, 32'd0, 32'd0, 8'd0),
                       ROW_PREDICT, NO_RSP});
      rows.push_back('{done_req(1'b1, 32'd0, bost_pkg::CSW_SIGNATURE, 32'd4, 32'hFFFF_FFFF,
                                8'd1),
                       ROW_PREDICT, NO_RSP});

      foreach (rows[i]) begin
         idle_gap();
         apply(rows[i].req, rows[i].kind, rows[i].want, produced);
      end

      // Random phases; each one drains the block before the registers change
      for (run = 0; run < 4; run++) begin
         drain();
         case (run)
            0:       set_config(4'd0, 4'd0, 8'd0);
            1:       set_config(4'd15, 4'd15, 8'd255);
            default: set_config(4'($urandom), 4'($urandom), 8'($urandom));
         endcase
         counted = 0;
         while (counted < PHASE_REQUESTS) begin
            // Run a long stretch of the third phase with no idling on either side
            calm = (run == 2) && (counted < CALM_REQUESTS);
            idle_gap();
            apply(gen_request(), ROW_PREDICT, NO_RSP, produced);
            if (produced) counted++;
         end
         calm = 1'b0;
      end

      drain();
      if (errors == 0)
         $display("bulk_only_storage_transport: match");
      else
         $display("bulk_only_storage_transport: mismatch");
      $finish;
   end

endmodule
